// ===== src/plg_pkg.sv =====
// Shared constants, types and helper functions for the polar grid lookup block.
`default_nettype none

package plg_pkg;

   // Table sizes.
   localparam int WATER_ENTRIES = 16;
   localparam int WIND_ENTRIES  = 16;
   localparam int ANGLE_ENTRIES = 64;

   localparam int MAX_ENTRIES_WW = (WATER_ENTRIES > WIND_ENTRIES) ? WATER_ENTRIES : WIND_ENTRIES;
   localparam int MAX_ENTRIES    = (MAX_ENTRIES_WW > ANGLE_ENTRIES) ? MAX_ENTRIES_WW
                                                                     : ANGLE_ENTRIES;
   localparam int FORCE_DEPTH    = WATER_ENTRIES * WIND_ENTRIES * ANGLE_ENTRIES;

   localparam int WATER_IW = (WATER_ENTRIES > 1) ? $clog2(WATER_ENTRIES) : 1;
   localparam int WIND_IW  = (WIND_ENTRIES > 1) ? $clog2(WIND_ENTRIES) : 1;
   localparam int ANGLE_IW = (ANGLE_ENTRIES > 1) ? $clog2(ANGLE_ENTRIES) : 1;
   localparam int CNT_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int USED_W   = $clog2(MAX_ENTRIES + 1);
   localparam int FA_W     = (FORCE_DEPTH > 1) ? $clog2(FORCE_DEPTH) : 1;

   // Fixed field widths.
   localparam int FUNC_W        = 3;
   localparam int WATER_SLOT_W  = 4;
   localparam int WIND_SLOT_W   = 4;
   localparam int ANGLE_SLOT_W  = 6;
   localparam int VALUE_W       = 32;
   localparam int DIFF_W        = VALUE_W + 1;
   localparam int WATER_CNT_W   = 5;
   localparam int WIND_CNT_W    = 5;
   localparam int ANGLE_CNT_W   = 7;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 7;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD_WATER = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_WIND  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_ANGLE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_FORCE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_WATER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIND_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_COUNT = 2'd2;

   localparam logic [WATER_CNT_W-1:0] WATER_CNT_RESET = 5'd16;
   localparam logic [WIND_CNT_W-1:0]  WIND_CNT_RESET  = 5'd16;
   localparam logic [ANGLE_CNT_W-1:0] ANGLE_CNT_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FREAD,
      ST_FDATA,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic                     axis;
      logic [WATER_SLOT_W-1:0]  water_slot;
      logic [WIND_SLOT_W-1:0]   wind_slot;
      logic [ANGLE_SLOT_W-1:0]  angle_slot;
      logic signed [VALUE_W-1:0] load_value;
      logic signed [VALUE_W-1:0] speed_water;
      logic signed [VALUE_W-1:0] wind_speed;
      logic signed [VALUE_W-1:0] wind_angle;
   } req_payload_type;

   typedef struct packed {
      logic                      is_query;
      logic signed [VALUE_W-1:0] force_res;
      logic [WATER_SLOT_W-1:0]   near_water;
      logic [WIND_SLOT_W-1:0]    near_wind;
      logic [ANGLE_SLOT_W-1:0]   near_angle;
   } rsp_payload_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept_load;
      logic accept_query;
      logic walk;
      logic force_read;
      logic out_load;
      logic out_is_query;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic walk_last;
      logic out_busy;
   } sts_type;

   // A count of zero means one entry; a count above the table size means all of it.
   function automatic logic [USED_W-1:0] clamp_count(input logic [ANGLE_CNT_W-1:0] c,
                                                     input logic [USED_W-1:0] size);
      if (c == '0) begin
         return USED_W'(1);
      end
      if (32'(c) > 32'(size)) begin
         return size;
      end
      return USED_W'(c);
   endfunction

   // Exact magnitude of the difference of two Q16.16 values.
   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [VALUE_W-1:0] a,
                                                 input logic signed [VALUE_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   function automatic logic [FA_W-1:0] force_addr(input int unsigned w,
                                                  input int unsigned n,
                                                  input int unsigned a);
      return FA_W'((w * WIND_ENTRIES + n) * ANGLE_ENTRIES + a);
   endfunction

endpackage

`default_nettype wire

// ===== src/plg_req_if.sv =====
// Request channel of the polar grid lookup block.
`default_nettype none

interface plg_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [plg_pkg::FUNC_W-1:0]               func;
   logic                                     axis;
   logic [plg_pkg::WATER_SLOT_W-1:0]         water_slot;
   logic [plg_pkg::WIND_SLOT_W-1:0]          wind_slot;
   logic [plg_pkg::ANGLE_SLOT_W-1:0]         angle_slot;
   logic signed [plg_pkg::VALUE_W-1:0]       load_value;
   logic signed [plg_pkg::VALUE_W-1:0]       speed_water;
   logic signed [plg_pkg::VALUE_W-1:0]       wind_speed;
   logic signed [plg_pkg::VALUE_W-1:0]       wind_angle;

   modport source (output valid, func, axis, water_slot, wind_slot, angle_slot, load_value,
                   speed_water, wind_speed, wind_angle, input ready);
   modport sink (input valid, func, axis, water_slot, wind_slot, angle_slot, load_value,
                 speed_water, wind_speed, wind_angle, output ready);
endinterface

`default_nettype wire

// ===== src/plg_rsp_if.sv =====
// Response channel of the polar grid lookup block.
`default_nettype none

interface plg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 is_query;
   logic signed [plg_pkg::VALUE_W-1:0]   force_res;
   logic [plg_pkg::WATER_SLOT_W-1:0]     near_water;
   logic [plg_pkg::WIND_SLOT_W-1:0]      near_wind;
   logic [plg_pkg::ANGLE_SLOT_W-1:0]     near_angle;

   modport source (output valid, is_query, force_res, near_water, near_wind, near_angle,
                   input ready);
   modport sink (input valid, is_query, force_res, near_water, near_wind, near_angle,
                 output ready);
endinterface

`default_nettype wire

// ===== src/plg_csr_if.sv =====
// Configuration write channel of the polar grid lookup block.
`default_nettype none

interface plg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [plg_pkg::CSR_IDX_W-1:0]     idx;
   logic [plg_pkg::CSR_DATA_W-1:0]    wdata;

   modport source (output valid, idx, wdata, input ready);
   modport sink (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

// ===== src/plg_ctrl.sv =====
// Sequencing state machine for loads and nearest-entry queries.
`default_nettype none

module plg_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [plg_pkg::FUNC_W-1:0]   req_func,
   output logic                              req_ready,
   input  wire plg_pkg::sts_type             sts,
   output plg_pkg::cmd_type                  cmd
);

   plg_pkg::state_type state_ff;
   plg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         plg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == plg_pkg::FUNC_QUERY) begin
                  cmd.accept_query = 1'b1;
                  state_in         = plg_pkg::ST_WALK;
               end else begin
                  cmd.accept_load = 1'b1;
                  state_in        = plg_pkg::ST_ACK;
               end
            end
         end
         plg_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_last) begin
               state_in = plg_pkg::ST_DRAIN;
            end
         end
         plg_pkg::ST_DRAIN: begin
            // The last axis entries are compared in this cycle.
            state_in = plg_pkg::ST_FREAD;
         end
         plg_pkg::ST_FREAD: begin
            cmd.force_read = 1'b1;
            state_in       = plg_pkg::ST_FDATA;
         end
         plg_pkg::ST_FDATA: begin
            if (!sts.out_busy) begin
               cmd.out_load     = 1'b1;
               cmd.out_is_query = 1'b1;
               state_in         = plg_pkg::ST_IDLE;
            end
         end
         plg_pkg::ST_ACK: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = plg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plg_pkg::ST_IDLE;
         end
      endcase
   end

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_busy)
      else $error("output register loaded while a response is still pending");

   a_query_walks: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_query |=> cmd.walk)
      else $error("query accepted but the axis walk did not start");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk && sts.walk_last) |=> (!cmd.walk && !req_ready))
      else $error("axis walk ran past its last entry");

   a_force_read_once: assert property (@(posedge clock) disable iff (reset)
      cmd.force_read |=> !cmd.force_read)
      else $error("force memory read issued twice for one query");

endmodule

`default_nettype wire

// ===== src/plg_dpath.sv =====
// Axis and force memories, nearest-entry compare units and the response register.
`default_nettype none

module plg_dpath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire plg_pkg::cmd_type                 cmd,
   output plg_pkg::sts_type                      sts,
   input  wire plg_pkg::req_payload_type         req,
   input  wire logic                             csr_valid,
   input  wire logic [plg_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  wire logic [plg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output plg_pkg::rsp_payload_type              rsp
);

   // Configuration registers.
   logic [plg_pkg::WATER_CNT_W-1:0] water_count_ff;
   logic [plg_pkg::WIND_CNT_W-1:0]  wind_count_ff;
   logic [plg_pkg::ANGLE_CNT_W-1:0] angle_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         water_count_ff <= plg_pkg::WATER_CNT_RESET;
         wind_count_ff  <= plg_pkg::WIND_CNT_RESET;
         angle_count_ff <= plg_pkg::ANGLE_CNT_RESET;
      end else if (csr_valid) begin
         case (csr_idx)
            plg_pkg::CSR_WATER_COUNT: water_count_ff <= csr_wdata[plg_pkg::WATER_CNT_W-1:0];
            plg_pkg::CSR_WIND_COUNT:  wind_count_ff  <= csr_wdata[plg_pkg::WIND_CNT_W-1:0];
            plg_pkg::CSR_ANGLE_COUNT: angle_count_ff <= csr_wdata[plg_pkg::ANGLE_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Entries in use, taken when a query is accepted.
   logic [plg_pkg::USED_W-1:0] water_used_in;
   logic [plg_pkg::USED_W-1:0] wind_used_in;
   logic [plg_pkg::USED_W-1:0] angle_used_in;
   logic [plg_pkg::USED_W-1:0] max_used;
   logic [plg_pkg::USED_W-1:0] water_used_ff;
   logic [plg_pkg::USED_W-1:0] wind_used_ff;
   logic [plg_pkg::USED_W-1:0] angle_used_ff;
   logic [plg_pkg::CNT_W-1:0]  walk_last_ff;

   always_comb begin
      water_used_in = plg_pkg::clamp_count(plg_pkg::ANGLE_CNT_W'(water_count_ff),
                                           plg_pkg::USED_W'(plg_pkg::WATER_ENTRIES));
      wind_used_in  = plg_pkg::clamp_count(plg_pkg::ANGLE_CNT_W'(wind_count_ff),
                                           plg_pkg::USED_W'(plg_pkg::WIND_ENTRIES));
      angle_used_in = plg_pkg::clamp_count(angle_count_ff,
                                           plg_pkg::USED_W'(plg_pkg::ANGLE_ENTRIES));
      max_used = water_used_in;
      if (wind_used_in > max_used) begin
         max_used = wind_used_in;
      end
      if (angle_used_in > max_used) begin
         max_used = angle_used_in;
      end
   end

   // Query operands.
   logic                               axis_ff;
   logic signed [plg_pkg::VALUE_W-1:0] speed_water_ff;
   logic signed [plg_pkg::VALUE_W-1:0] wind_speed_ff;
   logic signed [plg_pkg::VALUE_W-1:0] wind_angle_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept_query) begin
         axis_ff        <= req.axis;
         speed_water_ff <= req.speed_water;
         wind_speed_ff  <= req.wind_speed;
         wind_angle_ff  <= req.wind_angle;
         water_used_ff  <= water_used_in;
         wind_used_ff   <= wind_used_in;
         angle_used_ff  <= angle_used_in;
         walk_last_ff   <= plg_pkg::CNT_W'(max_used - plg_pkg::USED_W'(1));
      end
   end

   // Walk counter and read-data tag.
   logic [plg_pkg::CNT_W-1:0] cnt_ff;
   logic [plg_pkg::CNT_W-1:0] idx_d_ff;
   logic                      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.walk;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_query) begin
         cnt_ff <= '0;
      end else if (cmd.walk) begin
         cnt_ff <= cnt_ff + plg_pkg::CNT_W'(1);
      end
      idx_d_ff <= cnt_ff;
   end

   assign sts.walk_last = (cnt_ff == walk_last_ff);

   // Load write enables.
   logic                      water_we;
   logic                      wind_we;
   logic                      angle_we;
   logic                      force_we;
   logic [plg_pkg::FA_W-1:0]  load_faddr;
   logic [plg_pkg::FA_W-1:0]  query_faddr;

   always_comb begin
      water_we = cmd.accept_load && (req.func == plg_pkg::FUNC_LOAD_WATER) &&
                 (32'(req.water_slot) < plg_pkg::WATER_ENTRIES);
      wind_we  = cmd.accept_load && (req.func == plg_pkg::FUNC_LOAD_WIND) &&
                 (32'(req.wind_slot) < plg_pkg::WIND_ENTRIES);
      angle_we = cmd.accept_load && (req.func == plg_pkg::FUNC_LOAD_ANGLE) &&
                 (32'(req.angle_slot) < plg_pkg::ANGLE_ENTRIES);
      force_we = cmd.accept_load && (req.func == plg_pkg::FUNC_LOAD_FORCE) &&
                 (32'(req.water_slot) < plg_pkg::WATER_ENTRIES) &&
                 (32'(req.wind_slot) < plg_pkg::WIND_ENTRIES) &&
                 (32'(req.angle_slot) < plg_pkg::ANGLE_ENTRIES);
      load_faddr = plg_pkg::force_addr(32'(req.water_slot), 32'(req.wind_slot),
                                       32'(req.angle_slot));
   end

   // Axis memories: written by loads, read once per walk step.
   logic [plg_pkg::VALUE_W-1:0] water_mem [plg_pkg::WATER_ENTRIES];
   logic [plg_pkg::VALUE_W-1:0] wind_mem  [plg_pkg::WIND_ENTRIES];
   logic [plg_pkg::VALUE_W-1:0] angle_mem [plg_pkg::ANGLE_ENTRIES];
   logic signed [plg_pkg::VALUE_W-1:0] water_rd_ff;
   logic signed [plg_pkg::VALUE_W-1:0] wind_rd_ff;
   logic signed [plg_pkg::VALUE_W-1:0] angle_rd_ff;

   always_ff @(posedge clock) begin
      if (water_we) begin
         water_mem[plg_pkg::WATER_IW'(req.water_slot)] <= req.load_value;
      end
      if (cmd.walk) begin
         water_rd_ff <= water_mem[plg_pkg::WATER_IW'(cnt_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (wind_we) begin
         wind_mem[plg_pkg::WIND_IW'(req.wind_slot)] <= req.load_value;
      end
      if (cmd.walk) begin
         wind_rd_ff <= wind_mem[plg_pkg::WIND_IW'(cnt_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (angle_we) begin
         angle_mem[plg_pkg::ANGLE_IW'(req.angle_slot)] <= req.load_value;
      end
      if (cmd.walk) begin
         angle_rd_ff <= angle_mem[plg_pkg::ANGLE_IW'(cnt_ff)];
      end
   end

   // Running nearest entry per axis. Entry zero always seeds the search, and a
   // strict compare keeps the lowest index on a tie.
   logic [plg_pkg::DIFF_W-1:0]   water_ad;
   logic [plg_pkg::DIFF_W-1:0]   wind_ad;
   logic [plg_pkg::DIFF_W-1:0]   angle_ad;
   logic                         water_hit;
   logic                         wind_hit;
   logic                         angle_hit;
   logic                         first_entry;
   logic [plg_pkg::DIFF_W-1:0]   water_best_ff;
   logic [plg_pkg::DIFF_W-1:0]   wind_best_ff;
   logic [plg_pkg::DIFF_W-1:0]   angle_best_ff;
   logic [plg_pkg::WATER_IW-1:0] water_idx_ff;
   logic [plg_pkg::WIND_IW-1:0]  wind_idx_ff;
   logic [plg_pkg::ANGLE_IW-1:0] angle_idx_ff;

   always_comb begin
      first_entry = (idx_d_ff == '0);
      water_ad    = plg_pkg::abs_diff(water_rd_ff, speed_water_ff);
      wind_ad     = plg_pkg::abs_diff(wind_rd_ff, wind_speed_ff);
      angle_ad    = plg_pkg::abs_diff(angle_rd_ff, wind_angle_ff);
      water_hit   = rd_valid_ff && (32'(idx_d_ff) < 32'(water_used_ff)) &&
                    (first_entry || (water_ad < water_best_ff));
      wind_hit    = rd_valid_ff && (32'(idx_d_ff) < 32'(wind_used_ff)) &&
                    (first_entry || (wind_ad < wind_best_ff));
      angle_hit   = rd_valid_ff && (32'(idx_d_ff) < 32'(angle_used_ff)) &&
                    (first_entry || (angle_ad < angle_best_ff));
   end

   always_ff @(posedge clock) begin
      if (water_hit) begin
         water_best_ff <= water_ad;
         water_idx_ff  <= plg_pkg::WATER_IW'(idx_d_ff);
      end
      if (wind_hit) begin
         wind_best_ff <= wind_ad;
         wind_idx_ff  <= plg_pkg::WIND_IW'(idx_d_ff);
      end
      if (angle_hit) begin
         angle_best_ff <= angle_ad;
         angle_idx_ff  <= plg_pkg::ANGLE_IW'(idx_d_ff);
      end
   end

   // Force memories.
   logic [plg_pkg::VALUE_W-1:0] force_x_mem [plg_pkg::FORCE_DEPTH];
   logic [plg_pkg::VALUE_W-1:0] force_y_mem [plg_pkg::FORCE_DEPTH];
   logic [plg_pkg::VALUE_W-1:0] force_x_rd_ff;
   logic [plg_pkg::VALUE_W-1:0] force_y_rd_ff;

   assign query_faddr = plg_pkg::force_addr(32'(water_idx_ff), 32'(wind_idx_ff),
                                            32'(angle_idx_ff));

   always_ff @(posedge clock) begin
      if (force_we && !req.axis) begin
         force_x_mem[load_faddr] <= req.load_value;
      end
      if (cmd.force_read) begin
         force_x_rd_ff <= force_x_mem[query_faddr];
      end
   end

   always_ff @(posedge clock) begin
      if (force_we && req.axis) begin
         force_y_mem[load_faddr] <= req.load_value;
      end
      if (cmd.force_read) begin
         force_y_rd_ff <= force_y_mem[query_faddr];
      end
   end

   // Response register.
   logic                     out_valid_ff;
   plg_pkg::rsp_payload_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_is_query) begin
            out_ff.is_query   <= 1'b1;
            out_ff.force_res  <= axis_ff ? force_y_rd_ff : force_x_rd_ff;
            out_ff.near_water <= plg_pkg::WATER_SLOT_W'(water_idx_ff);
            out_ff.near_wind  <= plg_pkg::WIND_SLOT_W'(wind_idx_ff);
            out_ff.near_angle <= plg_pkg::ANGLE_SLOT_W'(angle_idx_ff);
         end else begin
            out_ff <= '0;
         end
      end
   end

   assign sts.out_busy = out_valid_ff && !rsp_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp          = out_ff;

endmodule

`default_nettype wire

// ===== src/polar_nearest_grid_lookup.sv =====
// Top level of the polar grid lookup block.
`default_nettype none

// Holds three axis tables and two 3-D force tables that are loaded one entry per
// request, and answers a query with the force entry at the grid point nearest to
// the query values and the three chosen indices. A load is accepted, and its
// acknowledge is then put in the response register once that register is free. A
// query walks N entries, where N is the largest number of entries in use on any
// axis (64 with the full 64-entry angle axis): the walk reads one entry of each
// axis memory per cycle, all three axes in step, followed by one compare, one force
// memory read and the load of the response register. One request is worked at a
// time; the next one is accepted while the previous response still waits in the
// output register, and it then holds in its last step until that response is taken.
// Count registers are sampled when a query is accepted; the user must write them
// only while no request is in flight, and the block itself does not enforce this.
module polar_nearest_grid_lookup (
   input  wire logic        clock,
   input  wire logic        reset,
   plg_req_if.sink          req_bus,
   plg_rsp_if.source        rsp_bus,
   plg_csr_if.sink          csr_bus
);

   plg_pkg::cmd_type         cmd;
   plg_pkg::sts_type         sts;
   plg_pkg::req_payload_type req_payload;
   plg_pkg::rsp_payload_type rsp_payload;
   logic                     req_ready;
   logic                     rsp_valid;

   always_comb begin
      req_payload.func        = req_bus.func;
      req_payload.axis        = req_bus.axis;
      req_payload.water_slot  = req_bus.water_slot;
      req_payload.wind_slot   = req_bus.wind_slot;
      req_payload.angle_slot  = req_bus.angle_slot;
      req_payload.load_value  = req_bus.load_value;
      req_payload.speed_water = req_bus.speed_water;
      req_payload.wind_speed  = req_bus.wind_speed;
      req_payload.wind_angle  = req_bus.wind_angle;
   end

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.is_query   = rsp_payload.is_query;
   assign rsp_bus.force_res  = rsp_payload.force_res;
   assign rsp_bus.near_water = rsp_payload.near_water;
   assign rsp_bus.near_wind  = rsp_payload.near_wind;
   assign rsp_bus.near_angle = rsp_payload.near_angle;

   plg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   plg_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req       (req_payload),
      .csr_valid (csr_bus.valid),
      .csr_idx   (csr_bus.idx),
      .csr_wdata (csr_bus.wdata),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );

endmodule

`default_nettype wire
